/* rtl/core/jsr_pkg.sv */
// Package: item types, character codes and controller/datapath interface types.
`default_nettype none
package jsr_pkg;

    localparam int DEPTH_W = 4;
    localparam int CNT_W   = DEPTH_W + 1;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH = 4'd15;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;

    localparam logic [1:0] SEL_CHAR = 2'd0;
    localparam logic [1:0] SEL_NL   = 2'd1;
    localparam logic [1:0] SEL_SP   = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic       accept;
        logic       clear_pending;
        logic       inc_depth;
        logic       dec_depth;
        logic       emit;
        logic [1:0] sel;
        logic       last;
        logic       load_cnt;
        logic       dec_cnt;
        logic       upd_string;
        logic       set_pending;
        logic       reset_state;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic pending;
        logic str_open;
        logic depth_zero;
        logic cnt_one;
        logic in_close;
        logic lat_open;
        logic lat_close;
        logic lat_comma;
        logic lat_colon;
        logic lat_eot;
    } t_status;

endpackage
`default_nettype wire

/* rtl/core/jsr_dpath.sv */
// Datapath: parse state, latched item, indent counter and output register.
`default_nettype none
module jsr_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jsr_pkg::t_in_item i_in_item,
    input  wire jsr_pkg::t_cmd    i_cmd,
    input  wire logic             i_out_stall,
    output jsr_pkg::t_status      o_status,
    output logic                  o_out_valid,
    output jsr_pkg::t_out_item    o_out_item
);

    logic [jsr_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic                        r_str_open, n_str_open;
    logic                        r_escape, n_escape;
    logic                        r_pending, n_pending;
    logic                        r_out_valid, n_out_valid;
    logic [jsr_pkg::CNT_W-1:0]   r_cnt;
    jsr_pkg::t_in_item           r_lat;
    jsr_pkg::t_out_item          r_out;
    logic [7:0]                  out_byte;
    logic [7:0]                  c;

    assign c = r_lat.in_char;

    always_comb begin
        n_depth = r_depth;
        priority if (i_cmd.reset_state) begin
            n_depth = '0;
        end else if (i_cmd.inc_depth) begin
            if (r_depth < jsr_pkg::MAX_DEPTH) n_depth = r_depth + jsr_pkg::DEPTH_W'(1);
        end else if (i_cmd.dec_depth) begin
            if (r_depth != '0) n_depth = r_depth - jsr_pkg::DEPTH_W'(1);
        end else begin
            n_depth = r_depth;
        end
    end

    always_comb begin
        n_str_open = r_str_open;
        n_escape   = r_escape;
        if (i_cmd.reset_state) begin
            n_str_open = 1'b0;
            n_escape   = 1'b0;
        end else if (i_cmd.upd_string) begin
            priority if (r_str_open) begin
                priority if (r_escape) begin
                    n_escape = 1'b0;
                end else if (c == jsr_pkg::CH_BSLASH) begin
                    n_escape = 1'b1;
                end else if (c == jsr_pkg::CH_QUOTE) begin
                    n_str_open = 1'b0;
                end else begin
                    n_escape = r_escape;
                end
            end else if (c == jsr_pkg::CH_QUOTE) begin
                n_str_open = 1'b1;
            end else begin
                n_str_open = r_str_open;
            end
        end
    end

    always_comb begin
        n_pending = r_pending;
        priority if (i_cmd.reset_state || i_cmd.clear_pending) begin
            n_pending = 1'b0;
        end else if (i_cmd.set_pending) begin
            n_pending = 1'b1;
        end else begin
            n_pending = r_pending;
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            jsr_pkg::SEL_NL: out_byte = jsr_pkg::CH_NL;
            jsr_pkg::SEL_SP: out_byte = jsr_pkg::CH_SP;
            default:         out_byte = c;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_str_open  <= 1'b0;
            r_escape    <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_str_open  <= n_str_open;
            r_escape    <= n_escape;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_lat <= i_in_item;
        if (i_cmd.load_cnt) begin
            r_cnt <= {r_depth, 1'b0};
        end else if (i_cmd.dec_cnt) begin
            r_cnt <= r_cnt - jsr_pkg::CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out.out_char <= out_byte;
            r_out.run_last <= i_cmd.last;
        end
    end

    assign o_status.slot_free  = !r_out_valid || !i_out_stall;
    assign o_status.pending    = r_pending;
    assign o_status.str_open   = r_str_open;
    assign o_status.depth_zero = (r_depth == '0);
    assign o_status.cnt_one    = (r_cnt == jsr_pkg::CNT_W'(1));
    assign o_status.in_close   = (i_in_item.in_char == jsr_pkg::CH_RBRACE) ||
                                 (i_in_item.in_char == jsr_pkg::CH_RBRACK);
    assign o_status.lat_open   = (c == jsr_pkg::CH_LBRACE) || (c == jsr_pkg::CH_LBRACK);
    assign o_status.lat_close  = (c == jsr_pkg::CH_RBRACE) || (c == jsr_pkg::CH_RBRACK);
    assign o_status.lat_comma  = (c == jsr_pkg::CH_COMMA);
    assign o_status.lat_colon  = (c == jsr_pkg::CH_COLON);
    assign o_status.lat_eot    = r_lat.end_of_text;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

/* rtl/core/jsr_ctrl.sv */
// Controller: sequences line breaks, indent runs and the byte of each item.
`default_nettype none
module jsr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire jsr_pkg::t_status i_status,
    output logic                 o_idle,
    output jsr_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PRE_NL   = 4'd1;
    localparam logic [3:0] ST_PRE_SP   = 4'd2;
    localparam logic [3:0] ST_CLOSE_NL = 4'd3;
    localparam logic [3:0] ST_CLOSE_SP = 4'd4;
    localparam logic [3:0] ST_CHAR     = 4'd5;
    localparam logic [3:0] ST_POST_NL  = 4'd6;
    localparam logic [3:0] ST_POST_SP  = 4'd7;
    localparam logic [3:0] ST_COLON_SP = 4'd8;

    logic [3:0] r_state, n_state;
    logic       main_close;
    logic       emit_ok;

    assign main_close = !i_status.str_open && i_status.lat_close;
    assign emit_ok    = i_status.slot_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_status.pending) begin
                        o_cmd.clear_pending = 1'b1;
                        if (i_status.in_close) begin
                            n_state = ST_CHAR;
                        end else begin
                            o_cmd.inc_depth = 1'b1;
                            n_state = ST_PRE_NL;
                        end
                    end else if (!i_status.str_open && i_status.in_close) begin
                        o_cmd.dec_depth = 1'b1;
                        n_state = ST_CLOSE_NL;
                    end else begin
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_PRE_NL, ST_PRE_SP: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (r_state == ST_PRE_NL) begin
                        o_cmd.sel      = jsr_pkg::SEL_NL;
                        o_cmd.load_cnt = 1'b1;
                    end else begin
                        o_cmd.sel     = jsr_pkg::SEL_SP;
                        o_cmd.dec_cnt = 1'b1;
                    end
                    if ((r_state == ST_PRE_NL) ? i_status.depth_zero : i_status.cnt_one) begin
                        if (main_close) begin
                            o_cmd.dec_depth = 1'b1;
                            n_state = ST_CLOSE_NL;
                        end else begin
                            n_state = ST_CHAR;
                        end
                    end else begin
                        n_state = ST_PRE_SP;
                    end
                end
            end
            ST_CLOSE_NL, ST_CLOSE_SP: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (r_state == ST_CLOSE_NL) begin
                        o_cmd.sel      = jsr_pkg::SEL_NL;
                        o_cmd.load_cnt = 1'b1;
                    end else begin
                        o_cmd.sel     = jsr_pkg::SEL_SP;
                        o_cmd.dec_cnt = 1'b1;
                    end
                    if ((r_state == ST_CLOSE_NL) ? i_status.depth_zero : i_status.cnt_one) begin
                        n_state = ST_CHAR;
                    end else begin
                        n_state = ST_CLOSE_SP;
                    end
                end
            end
            ST_CHAR: begin
                if (emit_ok) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel        = jsr_pkg::SEL_CHAR;
                    o_cmd.upd_string = 1'b1;
                    n_state          = ST_IDLE;
                    if (!i_status.str_open) begin
                        priority if (i_status.lat_open) begin
                            if (i_status.lat_eot) begin
                                o_cmd.inc_depth = 1'b1;
                                n_state = ST_POST_NL;
                            end else begin
                                o_cmd.set_pending = 1'b1;
                            end
                        end else if (i_status.lat_comma) begin
                            n_state = ST_POST_NL;
                        end else if (i_status.lat_colon) begin
                            n_state = ST_COLON_SP;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_POST_NL, ST_POST_SP: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (r_state == ST_POST_NL) begin
                        o_cmd.sel      = jsr_pkg::SEL_NL;
                        o_cmd.load_cnt = 1'b1;
                    end else begin
                        o_cmd.sel     = jsr_pkg::SEL_SP;
                        o_cmd.dec_cnt = 1'b1;
                    end
                    if ((r_state == ST_POST_NL) ? i_status.depth_zero : i_status.cnt_one) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_POST_SP;
                    end
                end
            end
            ST_COLON_SP: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = jsr_pkg::SEL_SP;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (r_state != ST_IDLE && o_cmd.emit && n_state == ST_IDLE) begin
            o_cmd.last        = 1'b1;
            o_cmd.reset_state = i_status.lat_eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/json_stream_reindenter.sv */
// Top level: JSON reindenter, controller plus datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (in_char, end_of_text)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (out_char, run_last)
//
// An item is accepted, then the sequencer loads its output bytes (1 to 63) into the
// single output register one byte a cycle while the output is not stalled.
// A plain character yields one byte; a line break adds 1 + 2*depth bytes.
// Synchronous active-low reset clears the parse state; no clearing pass.
// Output stall holds the output register and the sequencer; input stays stalled
// until the last byte of the current item has been loaded.
`default_nettype none
module json_stream_reindenter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire jsr_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output jsr_pkg::t_out_item     o_out_item
);

    jsr_pkg::t_cmd    cmd;
    jsr_pkg::t_status status;
    logic             idle;

    jsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_idle     (idle),
        .o_cmd      (cmd)
    );

    jsr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !idle;

endmodule
`default_nettype wire

/* rtl/core/jsr_checker.sv */
// Checker: port-level properties of the reindenter, bound to the top level.
`default_nettype none
module jsr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire jsr_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while an item is being processed");

    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.run_last |-> o_in_stall)
        else $error("new item accepted before run finished");

endmodule

bind json_stream_reindenter jsr_checker u_jsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for json_stream_reindenter: directed table, random JSON documents, fragments and noise.
`default_nettype none
module testbench;

    localparam int DIR_ROWS   = 24;
    localparam int RAND_ITEMS = 460;
    localparam int RUN_MAX    = 63;
    localparam int LIMIT      = 400000;

    logic               i_clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    jsr_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    jsr_pkg::t_out_item out_item;

    json_stream_reindenter dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always #4 i_clk = ~i_clk;

    // directed rows: byte, end of text, repeat count, typed run ("" = from predictor)
    logic [7:0] dir_char [DIR_ROWS] = '{
        "a", jsr_pkg::CH_COLON, jsr_pkg::CH_COMMA, jsr_pkg::CH_RBRACK,
        jsr_pkg::CH_LBRACE, jsr_pkg::CH_RBRACK, jsr_pkg::CH_LBRACK, jsr_pkg::CH_QUOTE,
        jsr_pkg::CH_BSLASH, jsr_pkg::CH_QUOTE, 8'hFF, jsr_pkg::CH_QUOTE,
        jsr_pkg::CH_RBRACE, jsr_pkg::CH_LBRACE, 8'h00, jsr_pkg::CH_QUOTE,
        jsr_pkg::CH_LBRACE, jsr_pkg::CH_BSLASH, jsr_pkg::CH_LBRACK, jsr_pkg::CH_COMMA,
        jsr_pkg::CH_RBRACE, 8'h7F, jsr_pkg::CH_QUOTE, jsr_pkg::CH_COLON
    };
    bit dir_eot [DIR_ROWS] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1
    };
    int dir_reps [DIR_ROWS] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 17, 1, 1, 1, 1, 1
    };
    string dir_run [DIR_ROWS] = '{
        "a", ": ", ",\n", "\n]", "{", "]", "[", "\n  \"",
        "\\", "\"", "\377", "\"", "\n}", "{\n  ", "", "\"",
        "{", "\\", "", "", "", "", "\"", ": "
    };

    // predictor state
    logic [jsr_pkg::DEPTH_W-1:0] p_depth;
    bit                          p_str_open;
    bit                          p_escape;
    bit                          p_open_pending;

    logic [7:0]         run_bytes [$];
    jsr_pkg::t_out_item expected_q [$];
    jsr_pkg::t_in_item  doc_q [$];

    int idle_pct;
    int items_sent;
    int docs_sent;
    int bytes_checked = 0;
    int errors = 0;
    int cycles = 0;

    function automatic void emit_byte(input logic [7:0] b);
        if (run_bytes.size() < RUN_MAX)
            run_bytes.push_back(b);
    endfunction

    function automatic void emit_line_break();
        emit_byte(jsr_pkg::CH_NL);
        for (int i = 0; i < 2 * int'(p_depth); i++)
            emit_byte(jsr_pkg::CH_SP);
    endfunction

    function automatic void deepen();
        if (p_depth < jsr_pkg::MAX_DEPTH)
            p_depth++;
    endfunction

    function automatic void clear_parse_state();
        p_depth        = '0;
        p_str_open     = 1'b0;
        p_escape       = 1'b0;
        p_open_pending = 1'b0;
    endfunction

    function automatic void reindent(input jsr_pkg::t_in_item it);
        logic [7:0] c;
        bit         is_close;
        bit         closed_empty;
        c            = it.in_char;
        is_close     = (c == jsr_pkg::CH_RBRACE) || (c == jsr_pkg::CH_RBRACK);
        closed_empty = 1'b0;
        run_bytes.delete();
        if (p_open_pending) begin
            p_open_pending = 1'b0;
            if (is_close) begin
                emit_byte(c);
                closed_empty = 1'b1;
            end else begin
                deepen();
                emit_line_break();
            end
        end
        if (!closed_empty) begin
            if (p_str_open) begin
                emit_byte(c);
                if (p_escape)
                    p_escape = 1'b0;
                else if (c == jsr_pkg::CH_BSLASH)
                    p_escape = 1'b1;
                else if (c == jsr_pkg::CH_QUOTE)
                    p_str_open = 1'b0;
            end else if (c == jsr_pkg::CH_QUOTE) begin
                p_str_open = 1'b1;
                emit_byte(c);
            end else if (c == jsr_pkg::CH_LBRACE || c == jsr_pkg::CH_LBRACK) begin
                emit_byte(c);
                if (it.end_of_text) begin
                    deepen();
                    emit_line_break();
                end else begin
                    p_open_pending = 1'b1;
                end
            end else if (is_close) begin
                if (p_depth != 0)
                    p_depth--;
                emit_line_break();
                emit_byte(c);
            end else if (c == jsr_pkg::CH_COMMA) begin
                emit_byte(c);
                emit_line_break();
            end else if (c == jsr_pkg::CH_COLON) begin
                emit_byte(jsr_pkg::CH_COLON);
                emit_byte(jsr_pkg::CH_SP);
            end else begin
                emit_byte(c);
            end
        end
        if (it.end_of_text)
            clear_parse_state();
    endfunction

    function automatic void queue_run();
        jsr_pkg::t_out_item o;
        for (int i = 0; i < run_bytes.size(); i++) begin
            o.out_char = run_bytes[i];
            o.run_last = (i == run_bytes.size() - 1);
            expected_q.push_back(o);
        end
    endfunction

    task automatic send_item(input jsr_pkg::t_in_item it, input string typed);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            in_item  <= jsr_pkg::t_in_item'($urandom);
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        reindent(it);
        if (typed.len() != 0) begin
            run_bytes.delete();
            for (int i = 0; i < typed.len(); i++)
                run_bytes.push_back(typed[i]);
        end
        queue_run();
        items_sent++;
    endtask

    function automatic void put_char(input logic [7:0] c);
        jsr_pkg::t_in_item it;
        it.in_char     = c;
        it.end_of_text = 1'b0;
        doc_q.push_back(it);
    endfunction

    function automatic void put_scalar();
        int         n;
        logic [7:0] b;
        string      lit;
        case ($urandom_range(0, 2))
            0: begin
                put_char(jsr_pkg::CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        put_char(jsr_pkg::CH_BSLASH);
                        put_char(8'($urandom_range(0, 255)));
                    end else begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == jsr_pkg::CH_QUOTE || b == jsr_pkg::CH_BSLASH);
                        put_char(b);
                    end
                end
                put_char(jsr_pkg::CH_QUOTE);
            end
            1: begin
                if ($urandom_range(0, 3) == 0)
                    put_char("-");
                n = $urandom_range(1, 4);
                repeat (n) put_char(8'h30 + 8'($urandom_range(0, 9)));
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       lit = "true";
                    1:       lit = "false";
                    default: lit = "null";
                endcase
                for (int i = 0; i < lit.len(); i++)
                    put_char(lit[i]);
            end
        endcase
    endfunction

    function automatic void mark_end();
        jsr_pkg::t_in_item it;
        it = doc_q.pop_back();
        it.end_of_text = 1'b1;
        doc_q.push_back(it);
    endfunction

    function automatic void build_doc(input int max_nest);
        bit is_obj [0:31];
        int count [0:31];
        int sp;
        doc_q.delete();
        sp         = 1;
        is_obj[1]  = 1'($urandom_range(0, 1));
        count[1]   = 0;
        put_char(is_obj[1] ? jsr_pkg::CH_LBRACE : jsr_pkg::CH_LBRACK);
        while (sp > 0) begin
            if (count[sp] >= 4 || doc_q.size() > 30 ||
                    $urandom_range(0, 99) < (count[sp] == 0 ? 15 : 40)) begin
                put_char(is_obj[sp] ? jsr_pkg::CH_RBRACE : jsr_pkg::CH_RBRACK);
                sp--;
            end else begin
                if (count[sp] > 0)
                    put_char(jsr_pkg::CH_COMMA);
                count[sp]++;
                if (is_obj[sp]) begin
                    put_char(jsr_pkg::CH_QUOTE);
                    put_char(8'h61 + 8'($urandom_range(0, 25)));
                    put_char(jsr_pkg::CH_QUOTE);
                    put_char(jsr_pkg::CH_COLON);
                end
                if (sp < max_nest && doc_q.size() < 24 && $urandom_range(0, 99) < 35) begin
                    sp++;
                    is_obj[sp] = 1'($urandom_range(0, 1));
                    count[sp]  = 0;
                    put_char(is_obj[sp] ? jsr_pkg::CH_LBRACE : jsr_pkg::CH_LBRACK);
                end else begin
                    put_scalar();
                end
            end
        end
        mark_end();
    endfunction

    function automatic void build_deep_doc();
        int n;
        n = $urandom_range(14, 20);
        doc_q.delete();
        repeat (n) put_char($urandom_range(0, 1) ? jsr_pkg::CH_LBRACE : jsr_pkg::CH_LBRACK);
        put_scalar();
        repeat (n) put_char($urandom_range(0, 1) ? jsr_pkg::CH_RBRACE : jsr_pkg::CH_RBRACK);
        mark_end();
    endfunction

    function automatic void build_noise();
        logic [7:0] marks [8] = '{jsr_pkg::CH_LBRACE, jsr_pkg::CH_LBRACK,
                                  jsr_pkg::CH_RBRACE, jsr_pkg::CH_RBRACK,
                                  jsr_pkg::CH_COMMA, jsr_pkg::CH_COLON,
                                  jsr_pkg::CH_QUOTE, jsr_pkg::CH_BSLASH};
        jsr_pkg::t_in_item it;
        int                n;
        doc_q.delete();
        n = $urandom_range(1, 10);
        repeat (n) begin
            it.in_char     = $urandom_range(0, 1) ? marks[$urandom_range(0, 7)]
                                                  : 8'($urandom_range(0, 255));
            it.end_of_text = ($urandom_range(0, 3) == 0);
            doc_q.push_back(it);
        end
    endfunction

    // output side: random stall, compare against the oldest expected byte
    always @(posedge i_clk) begin
        jsr_pkg::t_out_item want;
        out_stall <= ($urandom_range(0, 99) < idle_pct);
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected output byte %02h", out_item.out_char);
                errors++;
            end else begin
                want = expected_q.pop_front();
                bytes_checked++;
                if (out_item.out_char !== want.out_char) begin
                    $error("out_char: expected %02h, got %02h", want.out_char, out_item.out_char);
                    errors++;
                end
                if (out_item.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timed out with %0d bytes still expected", expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        jsr_pkg::t_in_item it;
        int                sel;
        int                cut;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        items_sent     = 0;
        docs_sent      = 0;
        idle_pct       = 30;
        clear_parse_state();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            it.in_char     = dir_char[r];
            it.end_of_text = dir_eot[r];
            repeat (dir_reps[r]) send_item(it, dir_reps[r] == 1 ? dir_run[r] : "");
        end

        while (items_sent < RAND_ITEMS) begin
            idle_pct = (items_sent > 150 && items_sent < 270) ? 0 : 30;
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                build_doc($urandom_range(1, 6));
            end else if (sel < 76) begin
                build_deep_doc();
            end else if (sel < 88) begin
                // truncated document, possibly inside a string or escape
                build_doc($urandom_range(1, 4));
                cut = $urandom_range(1, doc_q.size());
                while (doc_q.size() > cut)
                    void'(doc_q.pop_back());
                mark_end();
            end else begin
                build_noise();
            end
            docs_sent++;
            foreach (doc_q[i])
                send_item(doc_q[i], "");
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d input items (%0d documents, fragments and noise runs)",
                 items_sent, docs_sent);
        $display("Checked %0d reindented bytes, %0d mismatches", bytes_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
